// File: design/rfrc_pkg.sv
// Shared types, constants and status codes for the radio frame receive checker.
package rfrc_pkg;

	localparam logic [7:0] FrameLength    = 8'd27;
	localparam logic [4:0] LastPosition   = 5'd29;
	localparam int         LqiCrcBit      = 7;
	localparam logic [7:0] SyncByteReset  = 8'hA5;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_LENGTH   = 3'd1;
	localparam logic [2:0] ST_MISMATCH = 3'd2;
	localparam logic [2:0] ST_OVERFLOW = 3'd3;
	localparam logic [2:0] ST_START    = 3'd4;

	typedef struct packed {
		logic [7:0] data;
		logic [4:0] pos;
		logic [2:0] reject;
	} q_entry_t;

	typedef struct packed {
		logic     valid;
		q_entry_t entry;
	} q_beat_t;

endpackage

// File: design/rfrc_front.sv
// Front end: tracks the byte position, screens the length byte and overflow flag and tags each beat.
module rfrc_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic [7:0]          rx_byte,
	input  logic                fifo_overflow,
	output rfrc_pkg::q_beat_t   push
);

	logic [4:0] pos_q;

	always_comb begin
		push.valid        = 1'b0;
		push.entry.data   = rx_byte;
		push.entry.pos    = pos_q;
		push.entry.reject = rfrc_pkg::ST_OK;
		if (accept) begin
			if (pos_q != 5'd0) begin
				push.valid = 1'b1;
			end else if (fifo_overflow) begin
				push.valid        = 1'b1;
				push.entry.reject = rfrc_pkg::ST_OVERFLOW;
			end else if (rx_byte != rfrc_pkg::FrameLength) begin
				push.valid        = 1'b1;
				push.entry.reject = rfrc_pkg::ST_LENGTH;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= 5'd0;
		end else if (accept) begin
			if (pos_q == 5'd0) begin
				if (!fifo_overflow && rx_byte == rfrc_pkg::FrameLength) begin
					pos_q <= 5'd1;
				end
			end else if (pos_q == rfrc_pkg::LastPosition) begin
				pos_q <= 5'd0;
			end else begin
				pos_q <= pos_q + 5'd1;
			end
		end
	end

endmodule

// File: design/rfrc_queue.sv
// Two-entry queue that decouples the front end from the back end.
module rfrc_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  rfrc_pkg::q_beat_t   push,
	input  logic                pop,
	output logic                full,
	output rfrc_pkg::q_beat_t   head
);

	rfrc_pkg::q_entry_t mem_q [2];
	logic               wr_ptr_q;
	logic               rd_ptr_q;
	logic [1:0]         count_q;
	logic               do_push;
	logic               do_pop;

	assign full       = (count_q == 2'd2);
	assign head       = {(count_q != 2'd0), mem_q[rd_ptr_q]};
	assign do_push    = push.valid && !full;
	assign do_pop     = pop && head.valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push.entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: design/rfrc_back.sv
// Back end: keeps the key, decodes the frame body, sums it and registers the result.
module rfrc_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [7:0]          sync_byte,
	input  rfrc_pkg::q_beat_t   head,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [2:0]          status,
	output logic [31:0]         random_key,
	output logic [31:0]         source_address,
	output logic [31:0]         destination_address,
	output logic [31:0]         command_word,
	output logic [31:0]         payload_word
);

	logic [7:0]  key_q   [4];
	logic [31:0] words_q [4];
	logic [31:0] cks_q;
	logic [12:0] sum_q;
	logic        sc_ok_q;
	logic        out_valid_q;

	logic [7:0]  b;
	logic [4:0]  p;
	logic [1:0]  lane;
	logic [1:0]  widx;
	logic [7:0]  dec;
	logic [2:0]  final_status;
	logic        emit;

	assign b    = head.entry.data;
	assign p    = head.entry.pos;
	assign lane = p[1:0];
	assign widx = 2'(p[4:2] - 3'd2);
	assign dec  = b - key_q[lane];
	assign pop  = head.valid && (!out_valid_q || !out_stall);
	assign emit = pop && (p == 5'd0 || p == rfrc_pkg::LastPosition);
	assign out_valid = out_valid_q;

	always_comb begin
		if (!b[rfrc_pkg::LqiCrcBit]) begin
			final_status = rfrc_pkg::ST_MISMATCH;
		end else if (!sc_ok_q) begin
			final_status = rfrc_pkg::ST_START;
		end else if (cks_q != {19'd0, sum_q}) begin
			final_status = rfrc_pkg::ST_MISMATCH;
		end else begin
			final_status = rfrc_pkg::ST_OK;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (p >= 5'd4 && p <= 5'd7) begin
				key_q[lane] <= b;
			end
			if (p >= 5'd8 && p <= 5'd23) begin
				words_q[widx][{lane, 3'b000} +: 8] <= dec;
			end
		end
		if (emit) begin
			if (p == 5'd0) begin
				status              <= head.entry.reject;
				random_key          <= 32'd0;
				source_address      <= 32'd0;
				destination_address <= 32'd0;
				command_word        <= 32'd0;
				payload_word        <= 32'd0;
			end else begin
				status              <= final_status;
				random_key          <= {key_q[3], key_q[2], key_q[1], key_q[0]};
				source_address      <= words_q[0];
				destination_address <= words_q[1];
				command_word        <= words_q[2];
				payload_word        <= words_q[3];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cks_q       <= 32'd0;
			sum_q       <= 13'd0;
			sc_ok_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (pop) begin
				if (p == 5'd1) begin
					sc_ok_q <= (b == sync_byte);
					sum_q   <= 13'd0;
				end else if (p >= 5'd4 && p <= 5'd7) begin
					sum_q <= sum_q + {5'd0, b};
				end else if (p >= 5'd8 && p <= 5'd23) begin
					sum_q <= sum_q + {5'd0, dec};
				end else if (p >= 5'd24 && p <= 5'd27) begin
					cks_q[{lane, 3'b000} +: 8] <= b;
				end
			end
		end
	end

endmodule

// File: design/rf_frame_receive_check.sv
// Top level of the radio frame checker: front end, queue, back end and sync byte register.
// The block takes one receive FIFO byte per cycle, back to back, as long as the result side keeps
// up. The front end tags each byte with its frame position and screens the length byte, a
// two-entry queue carries the tagged beats, and the back end decodes and sums them. The result is
// registered in the back end when it pops the beat that ends the frame, or a rejected length byte,
// from the queue, and out_valid is raised from a register set together with it. While a result
// waits, the back end stops taking beats, the queue fills to two entries and then the input stalls.
module rf_frame_receive_check (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	input  logic        fifo_overflow,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [31:0] random_key,
	output logic [31:0] source_address,
	output logic [31:0] destination_address,
	output logic [31:0] command_word,
	output logic [31:0] payload_word
);

	logic [7:0]        sync_byte_q;
	logic              accept;
	logic              pop;
	rfrc_pkg::q_beat_t push;
	rfrc_pkg::q_beat_t head;

	assign accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_byte_q <= rfrc_pkg::SyncByteReset;
		end else if (cfg_we) begin
			sync_byte_q <= cfg_wdata;
		end
	end

	rfrc_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.rx_byte       (rx_byte),
		.fifo_overflow (fifo_overflow),
		.push          (push)
	);

	rfrc_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.full   (in_stall),
		.head   (head)
	);

	rfrc_back u_back (
		.clk                 (clk),
		.arst_n              (arst_n),
		.sync_byte           (sync_byte_q),
		.head                (head),
		.pop                 (pop),
		.out_valid           (out_valid),
		.out_stall           (out_stall),
		.status              (status),
		.random_key          (random_key),
		.source_address      (source_address),
		.destination_address (destination_address),
		.command_word        (command_word),
		.payload_word        (payload_word)
	);

	a_full_has_head: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> head.valid)
		else $error("queue full without a head entry");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status <= rfrc_pkg::ST_START))
		else $error("status code out of range");

	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == rfrc_pkg::ST_LENGTH || status == rfrc_pkg::ST_OVERFLOW)
		|-> (random_key == 32'd0 && source_address == 32'd0 && payload_word == 32'd0))
		else $error("rejected frame carries nonzero fields");

	a_pop_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (head.valid && (!out_valid || !out_stall)))
		else $error("back end popped while its result was held");

endmodule

// File: tb/rf_frame_receive_check_tb.sv
// Self-checking testbench for rf_frame_receive_check with directed and random frames.
module rf_frame_receive_check_tb;

	localparam int HalfPeriod = 10;
	localparam int QuietLimit = 2000;
	localparam int SettleCycles = 8;

	typedef struct packed {
		logic [2:0]  st;
		logic [31:0] key;
		logic [31:0] src;
		logic [31:0] dst;
		logic [31:0] cmd;
		logic [31:0] pay;
	} frame_report_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [7:0]  cfg_wdata = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  rx_byte = '0;
	logic        fifo_overflow = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [2:0]  status;
	logic [31:0] random_key;
	logic [31:0] source_address;
	logic [31:0] destination_address;
	logic [31:0] command_word;
	logic [31:0] payload_word;

	bit idling_on = 1'b1;
	int errors = 0;
	int quiet_cycles = 0;
	int bytes_sent = 0;

	logic [7:0]  fm_sync_byte = rfrc_pkg::SyncByteReset;
	logic [4:0]  fm_pos = '0;
	logic [7:0]  fm_key [4] = '{default: '0};
	logic [31:0] fm_words [4] = '{default: '0};
	logic [31:0] fm_checksum = '0;
	logic [12:0] fm_sum = '0;
	logic        fm_start_ok = 1'b0;
	frame_report_t awaited_reports [$];

	always #HalfPeriod clk = ~clk;

	rf_frame_receive_check u_top (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cfg_we              (cfg_we),
		.cfg_wdata           (cfg_wdata),
		.in_valid            (in_valid),
		.in_stall            (in_stall),
		.rx_byte             (rx_byte),
		.fifo_overflow       (fifo_overflow),
		.out_valid           (out_valid),
		.out_stall           (out_stall),
		.status              (status),
		.random_key          (random_key),
		.source_address      (source_address),
		.destination_address (destination_address),
		.command_word        (command_word),
		.payload_word        (payload_word)
	);

	function automatic void track_frame_byte(input logic [7:0] b, input logic ovf);
		frame_report_t r;
		logic [7:0] d;
		logic [1:0] lane;
		r = '0;
		lane = fm_pos[1:0];
		if (fm_pos == 5'd0) begin
			if (ovf) begin
				r.st = rfrc_pkg::ST_OVERFLOW;
				awaited_reports.push_back(r);
			end else if (b != rfrc_pkg::FrameLength) begin
				r.st = rfrc_pkg::ST_LENGTH;
				awaited_reports.push_back(r);
			end else begin
				fm_pos = 5'd1;
			end
			return;
		end
		if (fm_pos == rfrc_pkg::LastPosition) begin
			if (!b[rfrc_pkg::LqiCrcBit])
				r.st = rfrc_pkg::ST_MISMATCH;
			else if (!fm_start_ok)
				r.st = rfrc_pkg::ST_START;
			else if (fm_checksum != {19'd0, fm_sum})
				r.st = rfrc_pkg::ST_MISMATCH;
			else
				r.st = rfrc_pkg::ST_OK;
			r.key = {fm_key[3], fm_key[2], fm_key[1], fm_key[0]};
			r.src = fm_words[0];
			r.dst = fm_words[1];
			r.cmd = fm_words[2];
			r.pay = fm_words[3];
			awaited_reports.push_back(r);
			fm_pos = '0;
			return;
		end
		if (fm_pos == 5'd1) begin
			fm_start_ok = (b == fm_sync_byte);
			fm_sum = '0;
		end else if (fm_pos >= 5'd4 && fm_pos <= 5'd7) begin
			fm_key[lane] = b;
			fm_sum = fm_sum + 13'(b);
		end else if (fm_pos >= 5'd8 && fm_pos <= 5'd23) begin
			d = b - fm_key[lane];
			fm_words[(int'(fm_pos) - 8) / 4][8*lane +: 8] = d;
			fm_sum = fm_sum + 13'(d);
		end else if (fm_pos >= 5'd24 && fm_pos <= 5'd27) begin
			fm_checksum[8*lane +: 8] = b;
		end
		fm_pos = fm_pos + 5'd1;
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic ovf);
		int gap;
		if (idling_on && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 11);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		fifo_overflow <= ovf;
		do @(posedge clk); while (in_stall);
		track_frame_byte(b, ovf);
		bytes_sent++;
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (awaited_reports.size() != 0) @(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic set_sync_byte(input logic [7:0] code);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_wdata <= code;
		@(posedge clk);
		cfg_we <= 1'b0;
		fm_sync_byte = code;
	endtask

	// The words are given decoded; the key is added back on the way out.
	task automatic send_frame(input logic [7:0] code, input logic [31:0] key,
			input logic [127:0] words, input logic [7:0] lqi, input logic [31:0] cks_flip);
		logic [31:0] sum;
		logic [31:0] cks;
		sum = '0;
		for (int i = 0; i < 4; i++) sum += key[8*i +: 8];
		for (int i = 0; i < 16; i++) sum += words[8*i +: 8];
		cks = sum ^ cks_flip;
		send_byte(rfrc_pkg::FrameLength, 1'b0);
		send_byte(code, 1'($urandom_range(0, 1)));
		send_byte(8'($urandom()), 1'($urandom_range(0, 1)));
		send_byte(8'($urandom()), 1'($urandom_range(0, 1)));
		for (int i = 0; i < 4; i++) send_byte(key[8*i +: 8], 1'($urandom_range(0, 1)));
		for (int i = 0; i < 16; i++)
			send_byte(8'(words[8*i +: 8] + key[8*(i%4) +: 8]), 1'($urandom_range(0, 1)));
		for (int i = 0; i < 4; i++) send_byte(cks[8*i +: 8], 1'($urandom_range(0, 1)));
		send_byte(8'($urandom()), 1'($urandom_range(0, 1)));
		send_byte(lqi, 1'($urandom_range(0, 1)));
	endtask

	task automatic send_random_frame();
		logic [31:0]  key;
		logic [127:0] words;
		logic [7:0]   code;
		logic [7:0]   lqi;
		logic [31:0]  flip;
		key = $urandom();
		words = {$urandom(), $urandom(), $urandom(), $urandom()};
		case ($urandom_range(0, 9))
			0: key = '1;
			1: key = '0;
			2: words = '1;
			3: words = '0;
			default: ;
		endcase
		code = ($urandom_range(0, 6) == 0) ? 8'($urandom()) : fm_sync_byte;
		lqi = 8'($urandom());
		lqi[rfrc_pkg::LqiCrcBit] = ($urandom_range(0, 6) != 0);
		flip = '0;
		if ($urandom_range(0, 6) == 0)
			flip = $urandom_range(0, 1) ? (32'd1 << $urandom_range(0, 31)) : ($urandom() | 32'd1);
		send_frame(code, key, words, lqi, flip);
	endtask

	task automatic run_random_block(input int count);
		int first;
		first = bytes_sent;
		while (bytes_sent - first < count) begin
			if ($urandom_range(0, 9) < 8)
				send_random_frame();
			else
				send_byte(8'($urandom()), 1'($urandom_range(0, 1)));
		end
		// A stray length byte may have opened a frame; finish it with noise.
		while (fm_pos != 5'd0) send_byte(8'($urandom()), 1'($urandom_range(0, 1)));
	endtask

	task automatic test_length_byte();
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(rfrc_pkg::FrameLength - 8'd1, 1'b0);
		send_byte(rfrc_pkg::FrameLength + 8'd1, 1'b0);
		send_byte(rfrc_pkg::FrameLength, 1'b1);
		send_byte(8'h00, 1'b1);
		send_byte(8'hFF, 1'b1);
	endtask

	task automatic test_status_priority();
		send_frame(rfrc_pkg::SyncByteReset, $urandom(), {4{$urandom()}}, 8'h80, '0);
		send_frame(rfrc_pkg::SyncByteReset, '1, '0, 8'hFF, '0);
		send_frame(rfrc_pkg::SyncByteReset, '0, '1, 8'hFF, '0);
		send_frame(~rfrc_pkg::SyncByteReset, $urandom(), {4{$urandom()}}, 8'h7F, 32'h1);
		send_frame(~rfrc_pkg::SyncByteReset, $urandom(), {4{$urandom()}}, 8'h80,
			32'h8000_0000);
		send_frame(rfrc_pkg::SyncByteReset, $urandom(), {4{$urandom()}}, 8'h80,
			32'h0001_0000);
		send_frame(rfrc_pkg::SyncByteReset, $urandom(), {4{$urandom()}}, 8'h00, '0);
	endtask

	task automatic test_sync_byte_register();
		logic [7:0] code;
		set_sync_byte(8'h00);
		send_frame(8'h00, $urandom(), {4{$urandom()}}, 8'h80, '0);
		send_frame(rfrc_pkg::SyncByteReset, $urandom(), {4{$urandom()}}, 8'h80, '0);
		set_sync_byte(8'hFF);
		send_frame(8'hFF, $urandom(), {4{$urandom()}}, 8'hC0, '0);
		send_frame(8'hFE, $urandom(), {4{$urandom()}}, 8'hC0, '0);
		code = 8'($urandom());
		set_sync_byte(code);
		send_frame(code, $urandom(), {4{$urandom()}}, 8'h80, '0);
	endtask

	task automatic test_random_traffic();
		run_random_block(430);
		set_sync_byte(8'($urandom()));
		run_random_block(430);
		set_sync_byte($urandom_range(0, 1) ? 8'h00 : 8'hFF);
		idling_on = 1'b0;
		run_random_block(430);
	endtask

	task automatic check_field(input string name, input logic [31:0] want_v,
			input logic [31:0] got_v);
		if (want_v !== got_v) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want_v, got_v);
			errors++;
		end
	endtask

	always @(posedge clk) begin : check_results
		frame_report_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (awaited_reports.size() == 0) begin
				$display("%0t: unexpected result beat, expected none, actual status %0d",
					$time, status);
				errors++;
			end else begin
				want = awaited_reports.pop_front();
				check_field("status", 32'(want.st), 32'(status));
				check_field("random_key", want.key, random_key);
				check_field("source_address", want.src, source_address);
				check_field("destination_address", want.dst, destination_address);
				check_field("command_word", want.cmd, command_word);
				check_field("payload_word", want.pay, payload_word);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QuietLimit) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		forever begin
			if (idling_on && $urandom_range(0, 3) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 11)) @(posedge clk);
				out_stall <= 1'b0;
			end
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_length_byte();
		test_status_priority();
		test_sync_byte_register();
		test_random_traffic();
		wait_idle();
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
